FILE: src/picture_unit_register_port_macros.svh
// ---------------------------------------------------------------------------
// picture unit register port assertion macros
// shared property forms for the register port checks
// ---------------------------------------------------------------------------
`ifndef PICTURE_UNIT_REGISTER_PORT_MACROS_SVH
`define PICTURE_UNIT_REGISTER_PORT_MACROS_SVH

// same-cycle implication, disabled in reset
`define PURP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define PURP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/purp_pkg.sv
// ---------------------------------------------------------------------------
// purp_pkg
// sizes, codes and types of the picture unit register port
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package purp_pkg;

  localparam int NAMETABLE_BYTES = 2048;
  localparam int SPRITE_BYTES    = 256;
  localparam int PALETTE_BYTES   = 64;

  localparam int NT_AW  = $clog2(NAMETABLE_BYTES);
  localparam int SP_AW  = $clog2(SPRITE_BYTES);
  localparam int PAL_AW = $clog2(PALETTE_BYTES);
  localparam int ADDR_W = 14;

  localparam logic [ADDR_W-1:0] PATTERN_END  = 14'h2000;
  localparam logic [ADDR_W-1:0] PALETTE_BASE = 14'h3F00;
  localparam logic [7:0]        NO_READ      = 8'hFF;

  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_READ   = 2'd1,
    ACT_STATUS = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    REG_CTRL     = 3'd0,
    REG_MASK     = 3'd1,
    REG_STATUS   = 3'd2,
    REG_SPR_ADDR = 3'd3,
    REG_SPR_DATA = 3'd4,
    REG_SCROLL   = 3'd5,
    REG_ADDR     = 3'd6,
    REG_DATA     = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_DIRECT,
    RD_NAMETABLE,
    RD_SPRITE
  } rd_kind_t;

  typedef struct packed {
    logic              nmi_enable;
    logic              background_on;
    logic              sprites_on;
    logic              tall_sprites;
    logic [1:0]        nametable_select;
    logic              background_table_high;
    logic              sprite_table_high;
    logic [8:0]        scroll_horizontal;
    logic [8:0]        scroll_vertical;
    logic [ADDR_W-1:0] current_address;
  } view_t;

endpackage

FILE: src/picture_unit_register_port.sv
// ---------------------------------------------------------------------------
// picture_unit_register_port
// cpu-side register port of a video unit with nametable, sprite and palette
// memories
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one bus access per word: action (write, read, status load),
//           register index and data byte; valid/ready handshake.
//   out_* : one word per accepted input: the byte read (0xFF when nothing
//           is read) and the register view after the access.
//   cfg_* : nametable mirroring select, always ready; write it only while
//           the block holds no word in flight.
//   Latency: a word accepted at edge t shows on out_* after edge t+1.
//   Throughput: one word per cycle; register state is updated at accept,
//   memory reads go through the one-cycle synchronous read ports and the
//   read buffer is loaded when the word leaves the read stage.
//   Reset: after rst_n the memories are swept to zero, one entry per cycle
//   over NAMETABLE_BYTES cycles (2048), with in_ready low meanwhile.
//   Stall: when out_ready is low the result is held, the read stage keeps
//   its word (re-reading its entry) and in_ready drops once both are full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "picture_unit_register_port_macros.svh"

module picture_unit_register_port (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_action,
  input  logic [2:0]                  in_reg_index,
  input  logic [7:0]                  in_write_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_read_data,
  output logic                        out_nmi_enable,
  output logic                        out_background_on,
  output logic                        out_sprites_on,
  output logic                        out_tall_sprites,
  output logic [1:0]                  out_nametable_select,
  output logic                        out_background_table_high,
  output logic                        out_sprite_table_high,
  output logic [8:0]                  out_scroll_horizontal,
  output logic [8:0]                  out_scroll_vertical,
  output logic [purp_pkg::ADDR_W-1:0] out_current_address,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_vertical_mirroring
);

  import purp_pkg::*;

  // memories
  logic [7:0] nt_mem  [NAMETABLE_BYTES];
  logic [7:0] sp_mem  [SPRITE_BYTES];
  logic [7:0] pal_mem [PALETTE_BYTES];

  // register state
  logic              mirror_r;
  logic [ADDR_W-1:0] vaddr_r, vaddr_nxt;
  logic              toggle_r, toggle_nxt;
  logic [7:0]        rbuf_r, rbuf_nxt;
  logic [7:0]        ctrl_r, ctrl_nxt;
  logic [1:0]        mask_r, mask_nxt;
  logic [7:0]        scroll_h_r, scroll_h_nxt;
  logic [7:0]        scroll_v_r, scroll_v_nxt;
  logic [7:0]        status_r, status_nxt;
  logic [SP_AW-1:0]  spr_ptr_r, spr_ptr_nxt;

  // clearing sweep
  logic [NT_AW-1:0] clr_r;
  logic             clr_done_r;

  // read stage
  logic             p_valid_r;
  rd_kind_t         p_kind_r;
  logic [7:0]       p_direct_r;
  view_t            p_view_r;
  logic [NT_AW-1:0] p_nt_addr_r;
  logic [SP_AW-1:0] p_sp_addr_r;

  // output stage
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_data_r, out_data_nxt;
  view_t      out_view_r;

  // memory ports
  logic [7:0]        nt_rdata_r, sp_rdata_r;
  logic [NT_AW-1:0]  nt_raddr, nt_waddr, nt_idx_c;
  logic [SP_AW-1:0]  sp_raddr, sp_waddr;
  logic [PAL_AW-1:0] pal_waddr;
  logic [7:0]        mem_wdata;
  logic              nt_we, sp_we, pal_we;
  logic              nt_wr_c, sp_wr_c, pal_wr_c;

  logic              acc, p_adv;
  rd_kind_t          kind_c;
  logic [7:0]        direct_c;
  view_t             view_c;
  logic [10:0]       nt_mirror_c;
  logic [ADDR_W-1:0] vaddr_inc_c, pal_off_c;
  logic              in_pattern_c, in_palette_c;

  assign cfg_ready = 1'b1;
  assign p_adv     = !out_valid_r || out_ready;
  assign in_ready  = clr_done_r && (!p_valid_r || p_adv);
  assign acc       = in_valid && in_ready;

  // address decode of the current video address
  assign nt_mirror_c  = mirror_r ? vaddr_r[10:0] : {vaddr_r[11], vaddr_r[9:0]};
  assign nt_idx_c     = NT_AW'(nt_mirror_c);
  assign vaddr_inc_c  = vaddr_r + (ctrl_r[2] ? ADDR_W'(32) : ADDR_W'(1));
  assign pal_off_c    = vaddr_r - PALETTE_BASE;
  assign in_pattern_c = vaddr_r < PATTERN_END;
  assign in_palette_c = vaddr_r >= PALETTE_BASE;

  // access decode and register update at accept
  always_comb begin
    vaddr_nxt    = vaddr_r;
    toggle_nxt   = toggle_r;
    ctrl_nxt     = ctrl_r;
    mask_nxt     = mask_r;
    scroll_h_nxt = scroll_h_r;
    scroll_v_nxt = scroll_v_r;
    status_nxt   = status_r;
    spr_ptr_nxt  = spr_ptr_r;
    nt_wr_c      = 1'b0;
    sp_wr_c      = 1'b0;
    pal_wr_c     = 1'b0;
    kind_c       = RD_NONE;
    direct_c     = NO_READ;
    if (acc) begin
      unique case (action_t'(in_action))
        ACT_WRITE: begin
          unique case (reg_idx_t'(in_reg_index))
            REG_CTRL: ctrl_nxt = in_write_data;
            REG_MASK: mask_nxt = {in_write_data[4], in_write_data[3]};
            REG_SPR_ADDR: spr_ptr_nxt = in_write_data;
            REG_SPR_DATA: begin
              sp_wr_c     = 1'b1;
              spr_ptr_nxt = spr_ptr_r + SP_AW'(1);
            end
            REG_SCROLL: begin
              toggle_nxt = !toggle_r;
              if (!toggle_r) begin
                scroll_h_nxt = in_write_data;
              end else begin
                scroll_v_nxt = in_write_data;
              end
            end
            REG_ADDR: begin
              toggle_nxt = !toggle_r;
              if (!toggle_r) begin
                vaddr_nxt = {in_write_data[5:0], vaddr_r[7:0]};
              end else begin
                vaddr_nxt = {vaddr_r[13:8], in_write_data};
              end
            end
            REG_DATA: begin
              if (in_palette_c) begin
                pal_wr_c = 1'b1;
              end else if (!in_pattern_c) begin
                nt_wr_c = 1'b1;
              end
              vaddr_nxt = vaddr_inc_c;
            end
            default: ;
          endcase
        end
        ACT_READ: begin
          unique case (reg_idx_t'(in_reg_index))
            REG_STATUS: begin
              kind_c     = RD_DIRECT;
              direct_c   = status_r;
              toggle_nxt = 1'b0;
              status_nxt = {1'b0, status_r[6:0]};
            end
            REG_SPR_DATA: kind_c = RD_SPRITE;
            REG_DATA: begin
              if (!in_pattern_c && !in_palette_c) begin
                kind_c = RD_NAMETABLE;
              end
              vaddr_nxt = vaddr_inc_c;
            end
            default: ;
          endcase
        end
        ACT_STATUS: status_nxt = in_write_data;
        default: ;
      endcase
    end
    view_c.nmi_enable            = ctrl_nxt[7];
    view_c.background_on         = mask_nxt[0];
    view_c.sprites_on            = mask_nxt[1];
    view_c.tall_sprites          = ctrl_nxt[5];
    view_c.nametable_select      = ctrl_nxt[1:0];
    view_c.background_table_high = ctrl_nxt[4];
    view_c.sprite_table_high     = ctrl_nxt[5] ? 1'b0 : ctrl_nxt[3];
    view_c.scroll_horizontal     = {ctrl_nxt[0], scroll_h_nxt};
    view_c.scroll_vertical       = {ctrl_nxt[1], scroll_v_nxt};
    view_c.current_address       = vaddr_nxt;
  end

  // read stage to output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    rbuf_nxt      = rbuf_r;
    if (p_valid_r && p_adv) begin
      out_valid_nxt = 1'b1;
      case (p_kind_r)
        RD_DIRECT: out_data_nxt = p_direct_r;
        RD_NAMETABLE: begin
          out_data_nxt = rbuf_r;
          rbuf_nxt     = nt_rdata_r;
        end
        RD_SPRITE: out_data_nxt = sp_rdata_r;
        default:   out_data_nxt = NO_READ;
      endcase
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // memory port muxing, sweep has priority
  assign nt_we     = !clr_done_r || nt_wr_c;
  assign sp_we     = !clr_done_r || sp_wr_c;
  assign pal_we    = !clr_done_r || pal_wr_c;
  assign mem_wdata = clr_done_r ? in_write_data : 8'h00;
  assign nt_waddr  = clr_done_r ? nt_idx_c : clr_r;
  assign sp_waddr  = clr_done_r ? spr_ptr_r : clr_r[SP_AW-1:0];
  assign pal_waddr = clr_done_r ? pal_off_c[PAL_AW-1:0] : clr_r[PAL_AW-1:0];
  assign nt_raddr  = acc ? nt_idx_c : p_nt_addr_r;
  assign sp_raddr  = acc ? spr_ptr_r : p_sp_addr_r;

  always_ff @(posedge clk) begin
    if (nt_we) begin
      nt_mem[nt_waddr] <= mem_wdata;
    end
    nt_rdata_r <= nt_mem[nt_raddr];
  end

  always_ff @(posedge clk) begin
    if (sp_we) begin
      sp_mem[sp_waddr] <= mem_wdata;
    end
    sp_rdata_r <= sp_mem[sp_raddr];
  end

  always_ff @(posedge clk) begin
    if (pal_we) begin
      pal_mem[pal_waddr] <= mem_wdata;
    end
  end

  // control and architectural registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mirror_r    <= 1'b0;
      vaddr_r     <= '0;
      toggle_r    <= 1'b0;
      rbuf_r      <= '0;
      ctrl_r      <= '0;
      mask_r      <= '0;
      scroll_h_r  <= '0;
      scroll_v_r  <= '0;
      status_r    <= '0;
      spr_ptr_r   <= '0;
      clr_r       <= '0;
      clr_done_r  <= 1'b0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mirror_r <= cfg_vertical_mirroring;
      end
      vaddr_r     <= vaddr_nxt;
      toggle_r    <= toggle_nxt;
      rbuf_r      <= rbuf_nxt;
      ctrl_r      <= ctrl_nxt;
      mask_r      <= mask_nxt;
      scroll_h_r  <= scroll_h_nxt;
      scroll_v_r  <= scroll_v_nxt;
      status_r    <= status_nxt;
      spr_ptr_r   <= spr_ptr_nxt;
      if (!clr_done_r) begin
        clr_r <= clr_r + NT_AW'(1);
        if (clr_r == NT_AW'(NAMETABLE_BYTES - 1)) begin
          clr_done_r <= 1'b1;
        end
      end
      if (acc) begin
        p_valid_r <= 1'b1;
      end else if (p_adv) begin
        p_valid_r <= 1'b0;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (acc) begin
      p_kind_r    <= kind_c;
      p_direct_r  <= direct_c;
      p_view_r    <= view_c;
      p_nt_addr_r <= nt_idx_c;
      p_sp_addr_r <= spr_ptr_r;
    end
    out_data_r <= out_data_nxt;
    if (p_valid_r && p_adv) begin
      out_view_r <= p_view_r;
    end
  end

  assign out_valid                 = out_valid_r;
  assign out_read_data             = out_data_r;
  assign out_nmi_enable            = out_view_r.nmi_enable;
  assign out_background_on         = out_view_r.background_on;
  assign out_sprites_on            = out_view_r.sprites_on;
  assign out_tall_sprites          = out_view_r.tall_sprites;
  assign out_nametable_select      = out_view_r.nametable_select;
  assign out_background_table_high = out_view_r.background_table_high;
  assign out_sprite_table_high     = out_view_r.sprite_table_high;
  assign out_scroll_horizontal     = out_view_r.scroll_horizontal;
  assign out_scroll_vertical       = out_view_r.scroll_vertical;
  assign out_current_address       = out_view_r.current_address;

  // checks
  `PURP_ASSERT_NOW(a_no_accept_in_sweep, in_valid && in_ready, clr_done_r,
    "word accepted during memory sweep")
  `PURP_ASSERT_NOW(a_read_stage_free, in_valid && in_ready && p_valid_r, p_adv,
    "read stage overwritten while stalled")
  `PURP_ASSERT_NEXT(a_read_stage_holds, p_valid_r && !p_adv, p_valid_r,
    "stalled read stage lost its word")
  `PURP_ASSERT_NEXT(a_result_follows, p_valid_r && p_adv, out_valid,
    "read stage advanced without a result")

endmodule

FILE: verif/picture_unit_register_port_test.sv
// ---------------------------------------------------------------------------
// picture_unit_register_port_test
// self-checking bench for the cpu-side register port: a short table of
// bus accesses, then random access sequences under both mirroring modes,
// with random idling on both channels and one long output hold-off. every
// result word is checked field by field against a predictor of the port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module picture_unit_register_port_test;
  import purp_pkg::*;

  localparam logic [1:0] ACT_NONE    = 2'd3;
  localparam int         STALL_LIMIT = 12000;
  localparam int         LONG_HOLD   = 120;
  localparam int         PHASE_WORDS = 118;

  typedef struct packed {
    logic [7:0] rd;
    view_t      view;
  } word_t;

  typedef struct {
    logic [1:0] act;
    logic [2:0] sel;
    logic [7:0] d;
    logic       known;
    logic [7:0] rd;
  } row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          in_action = '0;
  logic [2:0]          in_reg_index = '0;
  logic [7:0]          in_write_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [7:0]          out_read_data;
  logic                out_nmi_enable;
  logic                out_background_on;
  logic                out_sprites_on;
  logic                out_tall_sprites;
  logic [1:0]          out_nametable_select;
  logic                out_background_table_high;
  logic                out_sprite_table_high;
  logic [8:0]          out_scroll_horizontal;
  logic [8:0]          out_scroll_vertical;
  logic [ADDR_W-1:0]   out_current_address;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic                cfg_vertical_mirroring = 1'b0;

  // predictor state
  logic                mirror_vertical;
  logic [ADDR_W-1:0]   vram_addr;
  logic                flip;
  logic [7:0]          read_latch;
  logic [7:0]          ctrl_reg;
  logic [1:0]          mask_reg;
  logic [8:0]          scroll_h;
  logic [8:0]          scroll_v;
  logic [7:0]          status_reg;
  logic [7:0]          oam_ptr;
  logic [7:0]          nt_mem  [NAMETABLE_BYTES];
  logic [7:0]          oam_mem [SPRITE_BYTES];
  logic [7:0]          pal_mem [PALETTE_BYTES];

  word_t pending_words[$];

  int  mismatches = 0;
  int  words_sent = 0;
  int  words_checked = 0;
  int  buffered_reads = 0;
  int  mirroring_writes = 0;
  int  idle_cycles = 0;
  bit  gappy = 1'b1;
  bit  quiet = 1'b0;
  bit  long_hold_pending = 1'b0;

  row_t script [29] = '{
    '{ACT_READ,   REG_STATUS,   8'h00, 1'b1, 8'h00},
    '{ACT_STATUS, REG_STATUS,   8'hFF, 1'b1, 8'hFF},
    '{ACT_READ,   REG_STATUS,   8'h00, 1'b1, 8'hFF},
    '{ACT_READ,   REG_STATUS,   8'h00, 1'b1, 8'h7F},
    '{ACT_WRITE,  REG_STATUS,   8'h55, 1'b1, 8'hFF},
    '{ACT_NONE,   REG_DATA,     8'hAA, 1'b1, 8'hFF},
    '{ACT_WRITE,  REG_CTRL,     8'hFF, 1'b1, 8'hFF},
    '{ACT_WRITE,  REG_MASK,     8'hFF, 1'b1, 8'hFF},
    '{ACT_READ,   REG_CTRL,     8'h00, 1'b1, 8'hFF},
    '{ACT_WRITE,  REG_CTRL,     8'h04, 1'b0, 8'h00},
    '{ACT_WRITE,  REG_MASK,     8'h00, 1'b0, 8'h00},
    '{ACT_WRITE,  REG_SCROLL,   8'hFF, 1'b0, 8'h00},
    '{ACT_WRITE,  REG_SCROLL,   8'h80, 1'b0, 8'h00},
    '{ACT_WRITE,  REG_ADDR,     8'h3F, 1'b0, 8'h00},
    '{ACT_WRITE,  REG_ADDR,     8'hE0, 1'b0, 8'h00},
    '{ACT_WRITE,  REG_DATA,     8'h9C, 1'b0, 8'h00},
    '{ACT_READ,   REG_DATA,     8'h00, 1'b1, 8'hFF},
    '{ACT_WRITE,  REG_CTRL,     8'h00, 1'b0, 8'h00},
    '{ACT_WRITE,  REG_ADDR,     8'h2C, 1'b0, 8'h00},
    '{ACT_WRITE,  REG_ADDR,     8'h00, 1'b0, 8'h00},
    '{ACT_WRITE,  REG_DATA,     8'h5A, 1'b0, 8'h00},
    '{ACT_WRITE,  REG_ADDR,     8'h2C, 1'b0, 8'h00},
    '{ACT_WRITE,  REG_ADDR,     8'h00, 1'b0, 8'h00},
    '{ACT_READ,   REG_DATA,     8'h00, 1'b1, 8'h00},
    '{ACT_READ,   REG_DATA,     8'h00, 1'b0, 8'h00},
    '{ACT_WRITE,  REG_SPR_ADDR, 8'hFF, 1'b0, 8'h00},
    '{ACT_WRITE,  REG_SPR_DATA, 8'h5A, 1'b0, 8'h00},
    '{ACT_WRITE,  REG_SPR_ADDR, 8'hFF, 1'b0, 8'h00},
    '{ACT_READ,   REG_SPR_DATA, 8'h00, 1'b1, 8'h5A}
  };

  picture_unit_register_port i_dut (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .in_valid                  (in_valid),
    .in_ready                  (in_ready),
    .in_action                 (in_action),
    .in_reg_index              (in_reg_index),
    .in_write_data             (in_write_data),
    .out_valid                 (out_valid),
    .out_ready                 (out_ready),
    .out_read_data             (out_read_data),
    .out_nmi_enable            (out_nmi_enable),
    .out_background_on         (out_background_on),
    .out_sprites_on            (out_sprites_on),
    .out_tall_sprites          (out_tall_sprites),
    .out_nametable_select      (out_nametable_select),
    .out_background_table_high (out_background_table_high),
    .out_sprite_table_high     (out_sprite_table_high),
    .out_scroll_horizontal     (out_scroll_horizontal),
    .out_scroll_vertical       (out_scroll_vertical),
    .out_current_address       (out_current_address),
    .cfg_valid                 (cfg_valid),
    .cfg_ready                 (cfg_ready),
    .cfg_vertical_mirroring    (cfg_vertical_mirroring)
  );

  always #6 clk = ~clk;

  function automatic logic [NT_AW-1:0] nt_slot(logic [ADDR_W-1:0] a);
    if (mirror_vertical) begin
      return a[10:0];
    end
    return {a[11], a[9:0]};
  endfunction

  function automatic void advance_addr();
    vram_addr = vram_addr + (ctrl_reg[2] ? ADDR_W'(32) : ADDR_W'(1));
  endfunction

  function automatic word_t apply_access(logic [1:0] act, logic [2:0] sel, logic [7:0] d);
    word_t w;
    w.rd = NO_READ;
    case (act)
      ACT_WRITE: begin
        case (sel)
          REG_CTRL: begin
            ctrl_reg    = d;
            scroll_h[8] = d[0];
            scroll_v[8] = d[1];
          end
          REG_MASK:     mask_reg = {d[4], d[3]};
          REG_SPR_ADDR: oam_ptr = d;
          REG_SPR_DATA: begin
            oam_mem[oam_ptr] = d;
            oam_ptr = oam_ptr + 8'd1;
          end
          REG_SCROLL: begin
            flip = ~flip;
            if (flip) scroll_h[7:0] = d;
            else scroll_v[7:0] = d;
          end
          REG_ADDR: begin
            flip = ~flip;
            if (flip) vram_addr[13:8] = d[5:0];
            else vram_addr[7:0] = d;
          end
          REG_DATA: begin
            if (vram_addr >= PALETTE_BASE) begin
              pal_mem[PAL_AW'(vram_addr - PALETTE_BASE)] = d;
            end else if (vram_addr >= PATTERN_END) begin
              nt_mem[nt_slot(vram_addr)] = d;
            end
            advance_addr();
          end
          default: ;
        endcase
      end
      ACT_READ: begin
        case (sel)
          REG_STATUS: begin
            w.rd = status_reg;
            flip = 1'b0;
            status_reg[7] = 1'b0;
          end
          REG_SPR_DATA: w.rd = oam_mem[oam_ptr];
          REG_DATA: begin
            // nametable reads come through the one-byte buffer
            if (vram_addr >= PATTERN_END && vram_addr < PALETTE_BASE) begin
              w.rd = read_latch;
              read_latch = nt_mem[nt_slot(vram_addr)];
              buffered_reads++;
            end
            advance_addr();
          end
          default: ;
        endcase
      end
      ACT_STATUS: status_reg = d;
      default: ;
    endcase
    w.view.nmi_enable            = ctrl_reg[7];
    w.view.background_on         = mask_reg[0];
    w.view.sprites_on            = mask_reg[1];
    w.view.tall_sprites          = ctrl_reg[5];
    w.view.nametable_select      = ctrl_reg[1:0];
    w.view.background_table_high = ctrl_reg[4];
    w.view.sprite_table_high     = ctrl_reg[5] ? 1'b0 : ctrl_reg[3];
    w.view.scroll_horizontal     = scroll_h;
    w.view.scroll_vertical       = scroll_v;
    w.view.current_address       = vram_addr;
    return w;
  endfunction

  task automatic note_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0h, expected %0h (result %0d)", what, got, want,
             words_checked);
    mismatches++;
  endtask

  task automatic send_word(logic [1:0] act, logic [2:0] sel, logic [7:0] d,
                           logic known = 1'b0, logic [7:0] known_rd = 8'h00);
    word_t w;
    if (!quiet && gappy && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_reg_index  <= sel;
    in_write_data <= d;
    do @(posedge clk); while (!(in_valid && in_ready));
    w = apply_access(act, sel, d);
    if (known) w.rd = known_rd;
    pending_words.push_back(w);
    words_sent++;
  endtask

  task automatic write_mirroring(logic v);
    cfg_valid              <= 1'b1;
    cfg_vertical_mirroring <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    mirror_vertical = v;
    mirroring_writes++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_part(int n);
    int         start;
    int         reps;
    logic [7:0] hi;
    start = words_sent;
    while (words_sent - start < n) begin
      gappy = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          // optional status read and control write, address pair, then a run of data port accesses
          case ($urandom_range(0, 5))
            0:       hi = 8'($urandom_range(8'h00, 8'h1F));
            1:       hi = 8'h3F;
            2:       hi = 8'($urandom_range(0, 255));
            default: hi = 8'($urandom_range(8'h20, 8'h3E));
          endcase
          if ($urandom_range(0, 3) != 0) send_word(ACT_READ, REG_STATUS, 8'($urandom));
          if ($urandom_range(0, 1) == 0) send_word(ACT_WRITE, REG_CTRL, 8'($urandom) & 8'hFB);
          send_word(ACT_WRITE, REG_ADDR, hi);
          send_word(ACT_WRITE, REG_ADDR, 8'($urandom));
          reps = $urandom_range(1, 8);
          repeat (reps) begin
            send_word($urandom_range(0, 1) ? ACT_WRITE : ACT_READ, REG_DATA, 8'($urandom));
          end
        end
        4: begin
          if ($urandom_range(0, 3) != 0) send_word(ACT_READ, REG_STATUS, 8'($urandom));
          send_word(ACT_WRITE, REG_SCROLL, 8'($urandom));
          send_word(ACT_WRITE, REG_SCROLL, 8'($urandom));
        end
        5: begin
          send_word(ACT_WRITE, REG_SPR_ADDR, 8'($urandom));
          reps = $urandom_range(1, 6);
          repeat (reps) begin
            send_word($urandom_range(0, 1) ? ACT_WRITE : ACT_READ, REG_SPR_DATA,
                      8'($urandom));
          end
        end
        6: begin
          send_word(ACT_WRITE, REG_CTRL, 8'($urandom));
          send_word(ACT_WRITE, REG_MASK, 8'($urandom));
        end
        7: begin
          send_word(ACT_STATUS, 3'($urandom), 8'($urandom));
          reps = $urandom_range(1, 2);
          repeat (reps) send_word(ACT_READ, REG_STATUS, 8'($urandom));
        end
        default: begin
          reps = $urandom_range(1, 4);
          repeat (reps) send_word(2'($urandom), 3'($urandom), 8'($urandom));
        end
      endcase
    end
  endtask

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    word_t w;
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        note_mismatch("unexpected word", out_read_data, 0);
      end else begin
        w = pending_words.pop_front();
        if (out_read_data !== w.rd)
          note_mismatch("read_data", out_read_data, w.rd);
        if (out_nmi_enable !== w.view.nmi_enable)
          note_mismatch("nmi_enable", out_nmi_enable, w.view.nmi_enable);
        if (out_background_on !== w.view.background_on)
          note_mismatch("background_on", out_background_on, w.view.background_on);
        if (out_sprites_on !== w.view.sprites_on)
          note_mismatch("sprites_on", out_sprites_on, w.view.sprites_on);
        if (out_tall_sprites !== w.view.tall_sprites)
          note_mismatch("tall_sprites", out_tall_sprites, w.view.tall_sprites);
        if (out_nametable_select !== w.view.nametable_select)
          note_mismatch("nametable_select", out_nametable_select,
                        w.view.nametable_select);
        if (out_background_table_high !== w.view.background_table_high)
          note_mismatch("background_table_high", out_background_table_high,
                        w.view.background_table_high);
        if (out_sprite_table_high !== w.view.sprite_table_high)
          note_mismatch("sprite_table_high", out_sprite_table_high,
                        w.view.sprite_table_high);
        if (out_scroll_horizontal !== w.view.scroll_horizontal)
          note_mismatch("scroll_horizontal", out_scroll_horizontal,
                        w.view.scroll_horizontal);
        if (out_scroll_vertical !== w.view.scroll_vertical)
          note_mismatch("scroll_vertical", out_scroll_vertical, w.view.scroll_vertical);
        if (out_current_address !== w.view.current_address)
          note_mismatch("current_address", out_current_address,
                        w.view.current_address);
      end
      words_checked++;
    end
  end

  // limit covers the memory sweep after reset plus the long hold-off
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               idle_cycles, pending_words.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    mirror_vertical = 1'b0;
    vram_addr       = '0;
    flip            = 1'b0;
    read_latch      = '0;
    ctrl_reg        = '0;
    mask_reg        = '0;
    scroll_h        = '0;
    scroll_v        = '0;
    status_reg      = '0;
    oam_ptr         = '0;
    foreach (nt_mem[i]) nt_mem[i] = '0;
    foreach (oam_mem[i]) oam_mem[i] = '0;
    foreach (pal_mem[i]) pal_mem[i] = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    write_mirroring(1'b0);

    foreach (script[i]) begin
      send_word(script[i].act, script[i].sel, script[i].d, script[i].known, script[i].rd);
    end

    // mirroring 1, 0, 1, 0; long hold in the second pass, no idling in the last
    for (int p = 0; p < 4; p++) begin
      settle();
      write_mirroring(p[0] ? 1'b0 : 1'b1);
      if (p == 1) long_hold_pending = 1'b1;
      if (p == 3) quiet = 1'b1;
      random_part(PHASE_WORDS);
    end
    settle();

    $display("run covered %0d bus words and %0d result checks, %0d buffered nametable reads",
             words_sent, words_checked, buffered_reads);
    $display("mirroring written %0d times across both modes, with one long output hold-off",
             mirroring_writes);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: picture_unit_register_port.f
+incdir+src
src/purp_pkg.sv
src/picture_unit_register_port.sv
verif/picture_unit_register_port_test.sv
